// ===== hw/rtl/spv_pkg.sv =====
// Shared types, constants and CRC step function for the space packet validator.
`default_nettype none
package spv_pkg;

   // Packet layout
   localparam int unsigned HdrBytes  = 6;
   localparam int unsigned CrcBytes  = 2;
   localparam int unsigned PosWidth  = 17;
   localparam logic [10:0] IdleApid  = 11'h7FF;

   // Verdict codes
   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_BAD_VER  = 3'd1;
   localparam logic [2:0] STATUS_SHORT    = 3'd2;
   localparam logic [2:0] STATUS_CRC_BAD  = 3'd3;
   localparam logic [2:0] STATUS_IDLE_SEC = 3'd4;
   localparam logic [2:0] STATUS_IDLE_MT  = 3'd5;

   // Register indexes
   localparam logic [1:0] REG_CRC_ENABLE = 2'd0;
   localparam logic [1:0] REG_CRC_POLY   = 2'd1;
   localparam logic [1:0] REG_CRC_INIT   = 2'd2;
   localparam logic [1:0] REG_CRC_FXOR   = 2'd3;

   // Register reset values
   localparam logic        RstCrcEnable = 1'b1;
   localparam logic [15:0] RstCrcPoly   = 16'h1021;
   localparam logic [15:0] RstCrcInit   = 16'hFFFF;
   localparam logic [15:0] RstCrcFxor   = 16'h0000;

   typedef struct packed {
      logic        crc_enable;
      logic [15:0] crc_poly;
      logic [15:0] crc_init;
      logic [15:0] crc_final_xor;
   } cfg_type;

   typedef struct packed {
      logic [15:0] received_crc;
      logic [15:0] data_length;
      logic [13:0] sequence_count;
      logic [1:0]  sequence_flags;
      logic        secondary_flag;
      logic        packet_type;
      logic [10:0] apid;
      logic [2:0]  status;
   } result_type;

   // One byte of an MSB-first CRC-16
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b,
                                             input logic [15:0] poly);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ poly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/spv_csr.sv =====
// Configuration register file with an APB-style write/read port.
`default_nettype none
module spv_csr (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_psel,
   input  wire logic            csr_penable,
   input  wire logic            csr_pwrite,
   input  wire logic [3:0]      csr_paddr,
   input  wire logic [31:0]     csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output spv_pkg::cfg_type     cfg
);

   spv_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   // Update the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            spv_pkg::REG_CRC_ENABLE: cfg_in.crc_enable    = csr_pwdata[0];
            spv_pkg::REG_CRC_POLY:   cfg_in.crc_poly      = csr_pwdata[15:0];
            spv_pkg::REG_CRC_INIT:   cfg_in.crc_init      = csr_pwdata[15:0];
            spv_pkg::REG_CRC_FXOR:   cfg_in.crc_final_xor = csr_pwdata[15:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_enable    <= spv_pkg::RstCrcEnable;
         cfg_ff.crc_poly      <= spv_pkg::RstCrcPoly;
         cfg_ff.crc_init      <= spv_pkg::RstCrcInit;
         cfg_ff.crc_final_xor <= spv_pkg::RstCrcFxor;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      case (reg_idx)
         spv_pkg::REG_CRC_ENABLE: csr_prdata = {31'd0, cfg_ff.crc_enable};
         spv_pkg::REG_CRC_POLY:   csr_prdata = {16'd0, cfg_ff.crc_poly};
         spv_pkg::REG_CRC_INIT:   csr_prdata = {16'd0, cfg_ff.crc_init};
         spv_pkg::REG_CRC_FXOR:   csr_prdata = {16'd0, cfg_ff.crc_final_xor};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/spv_core.sv =====
// Packet parser: header capture, running CRC, tail delay and verdict logic.
`default_nettype none
module spv_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         data_byte,
   input  wire spv_pkg::cfg_type   cfg,
   output logic                    res_valid,
   output spv_pkg::result_type     res
);

   localparam logic [16:0] HdrLast  = 17'(spv_pkg::HdrBytes - 1);
   localparam logic [16:0] BodyMin  = 17'(spv_pkg::HdrBytes);
   localparam logic [16:0] TailFeed = 17'(spv_pkg::HdrBytes + spv_pkg::CrcBytes);
   localparam logic [16:0] PosMax   = 17'(spv_pkg::HdrBytes) + 17'h0FFFF;

   logic [16:0] pos_ff, pos_in;
   logic [47:0] hdr_ff, hdr_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] tail_ff, tail_in;

   logic        in_header;
   logic [15:0] crc_base;
   logic [15:0] crc_hdr;
   logic [15:0] crc_body;
   logic [16:0] body_idx;
   logic [15:0] len;
   logic [47:0] hdr_view;
   logic [2:0]  status;
   logic [15:0] rcrc;

   assign in_header = pos_ff < BodyMin;
   assign crc_base  = (pos_ff == 17'd0) ? cfg.crc_init : crc_ff;
   assign crc_hdr   = spv_pkg::crc_feed(crc_base, data_byte, cfg.crc_poly);
   assign crc_body  = (pos_ff >= TailFeed) ?
                      spv_pkg::crc_feed(crc_ff, tail_ff[15:8], cfg.crc_poly) : crc_ff;
   assign body_idx  = pos_ff - BodyMin;
   assign len       = hdr_ff[15:0];

   // Advance the packet state and decide the verdict for this byte
   always_comb begin
      pos_in    = pos_ff;
      hdr_in    = hdr_ff;
      crc_in    = crc_ff;
      tail_in   = tail_ff;
      res_valid = 1'b0;
      status    = spv_pkg::STATUS_OK;
      rcrc      = 16'd0;
      hdr_view  = hdr_ff;
      if (in_header) begin
         hdr_in   = {hdr_ff[39:0], data_byte};
         hdr_view = hdr_in;
         crc_in   = crc_hdr;
         pos_in   = pos_ff + 17'd1;
         if (pos_ff == HdrLast) begin
            tail_in = 16'd0;
            if (hdr_ff[39:37] != 3'd0) begin
               res_valid = 1'b1;
               status    = spv_pkg::STATUS_BAD_VER;
               pos_in    = 17'd0;
            end
         end
      end else begin
         crc_in  = crc_body;
         tail_in = {tail_ff[7:0], data_byte};
         if (body_idx < {1'b0, len}) begin
            pos_in = pos_ff + 17'd1;
         end else begin
            res_valid = 1'b1;
            pos_in    = 17'd0;
            if (cfg.crc_enable) begin
               if (len == 16'd0) begin
                  status = spv_pkg::STATUS_SHORT;
               end else begin
                  rcrc = tail_in;
                  if ((crc_body ^ cfg.crc_final_xor) != tail_in) begin
                     status = spv_pkg::STATUS_CRC_BAD;
                  end
               end
            end
            if (status == spv_pkg::STATUS_OK && hdr_ff[42:32] == spv_pkg::IdleApid) begin
               if (hdr_ff[43]) begin
                  status = spv_pkg::STATUS_IDLE_SEC;
               end else if (cfg.crc_enable && len == 16'd1) begin
                  status = spv_pkg::STATUS_IDLE_MT;
               end
            end
         end
      end
   end

   // Pack the result fields from the header
   always_comb begin
      res.status         = status;
      res.apid           = hdr_view[42:32];
      res.packet_type    = hdr_view[44];
      res.secondary_flag = hdr_view[43];
      res.sequence_flags = hdr_view[31:30];
      res.sequence_count = hdr_view[29:16];
      res.data_length    = hdr_view[15:0];
      res.received_crc   = rcrc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 17'd0;
         hdr_ff  <= 48'd0;
         crc_ff  <= spv_pkg::RstCrcInit;
         tail_ff <= 16'd0;
      end else if (step) begin
         pos_ff  <= pos_in;
         hdr_ff  <= hdr_in;
         crc_ff  <= crc_in;
         tail_ff <= tail_in;
      end
   end

   // Position never runs past the longest body
   a_pos_range: assert property (@(posedge clock) disable iff (reset) pos_ff <= PosMax)
      else $error("packet position out of range");

   // A verdict always restarts header collection
   a_verdict_restart: assert property (@(posedge clock) disable iff (reset)
      step && res_valid |=> pos_ff == 17'd0)
      else $error("position not cleared after verdict");

   // Header bytes never give a verdict except on a bad version at the sixth byte
   a_hdr_verdict: assert property (@(posedge clock) disable iff (reset)
      in_header && res_valid |-> pos_ff == HdrLast && status == spv_pkg::STATUS_BAD_VER)
      else $error("unexpected verdict during header");

endmodule
`default_nettype wire

// ===== hw/rtl/space_packet_validator_top.sv =====
// Top level of the space packet validator: stream ports, input and result registers.
// A request waits in the input register until the result slot can take a verdict; the parser
//   then takes it, and its verdict, if any, is loaded into the result register and shown on rsp_.
// Throughput: one byte per cycle while the result stream is not stalled; the single-byte CRC step
//   and the header/length compare fit between the input register and the result register.
// Reset (synchronous, active high) empties both registers, restarts header
//   collection and restores the register reset values; no clearing pass follows.
`default_nettype none
module space_packet_validator_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [2:0] status, [13:3] apid, [14] packet_type,
                                         // [15] secondary_flag, [17:16] sequence_flags,
                                         // [31:18] sequence_count, [47:32] data_length,
                                         // [63:48] received_crc
   // configuration
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   spv_pkg::cfg_type    cfg;
   spv_pkg::result_type res;
   logic                res_valid;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   logic [63:0] out_data_ff;
   logic       advance;
   logic       req_fire;

   spv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   spv_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   // Move the held request into the parser when the result slot can take a verdict
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Load a verdict, or drop the one just taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance && res_valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers hold without reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
      end
      if (advance && res_valid) begin
         out_data_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
`default_nettype wire
